[rtl/tsq_pkg.sv]
// Shared types and codes of the task scheduler queue.
package tsq_pkg;

    // One queued task as it sits in the slot memory.
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [7:0]  id;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_DROPPED  = 2'd1,
        STAT_SLICE    = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    localparam logic [2:0] MODE_FCFS    = 3'd0;
    localparam logic [2:0] MODE_SJF     = 3'd1;
    localparam logic [2:0] MODE_PRIO    = 3'd2;
    localparam logic [2:0] MODE_RR      = 3'd3;
    localparam logic [2:0] MODE_PRIO_RR = 3'd4;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    localparam logic REG_POLICY_MODE = 1'b0;
    localparam logic REG_TIME_SLICE  = 1'b1;

    localparam logic [15:0] SLICE_RESET = 16'd10;

endpackage

[rtl/task_scheduler_queue.sv]
// Top level of the task scheduler queue: slot memory, insertion and pop sequencer.
// An append (first come first served, round robin, unused modes, or an empty queue) and any
// dropped or empty-queue request pass through the result registers to the output register;
// a next request first reads the head slot in the pop state, a sorted insert walks the
// queue in the scan state. Throughput: one request at a time, the next one taken only
// after the result is loaded into the output register; the slot memory port, walked one slot
// per cycle, sets the sorted-insert time. Reset clears the queue count, pointers, time counter
// and registers (mode 0, slice 10); the slot memory is not cleared and needs no clearing pass.
module task_scheduler_queue #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // task_id[7:0], burst_length[23:8], task_priority[31:24]
    input  logic [0:0]  s_tuser,   // opcode[0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // run_task_id[7:0], run_length[23:8], start_time[55:24],
                                   // task_finished[56], zero fill[63:57]
    output logic [1:0]  m_tuser    // status[1:0]
);

    import tsq_pkg::*;

    localparam int PTR_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int ENT_W = $bits(entry_t);

    // The queue is a ring in the slot memory: head_reg is the oldest slot, tail_reg the
    // first free one. Logical position i lives at head + i, modulo MAX_TASKS.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(MAX_TASKS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        elapsed_reg, elapsed_next;
    logic [2:0]         mode_reg;
    logic [15:0]        slice_reg;

    // Insert walk: idx_reg is the logical position whose slot arrives on rd_data,
    // wptr_reg its physical slot, rptr_reg the slot read in the same cycle.
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic               found_reg, found_next;
    entry_t             req_reg, req_next;
    entry_t             carry_reg, carry_next;

    // Result waiting for the output register.
    status_t            res_status_reg, res_status_next;
    logic [7:0]         res_id_reg, res_id_next;
    logic [15:0]        res_run_reg, res_run_next;
    logic [31:0]        res_start_reg, res_start_next;
    logic               res_fin_reg, res_fin_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [7:0]         out_id_reg;
    logic [15:0]        out_run_reg;
    logic [31:0]        out_start_reg;
    logic               out_fin_reg;
    logic               out_load;

    logic               ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]   ram_wr_addr, ram_rd_addr;
    entry_t             ram_wr_data;
    logic [ENT_W-1:0]   ram_rd_bits;
    entry_t             slot;

    logic               sorted_mode, rr_mode, hit, place;
    logic               accept;
    logic [15:0]        run_len, left_len;

    assign slot   = entry_t'(ram_rd_bits);
    assign accept = s_tvalid && s_tready;

    tsq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_bits)
    );

    // Mode decode. Unused codes behave like first come first served.
    always_comb
    begin
        unique case (mode_reg) inside
            MODE_SJF, MODE_PRIO, MODE_PRIO_RR: sorted_mode = 1'b1;
            default:                           sorted_mode = 1'b0;
        endcase
        unique case (mode_reg) inside
            MODE_RR, MODE_PRIO_RR: rr_mode = 1'b1;
            default:               rr_mode = 1'b0;
        endcase
    end

    // Insertion compare: the new task goes in front of the first slot with a strictly
    // larger remaining time (shortest job first) or strictly lower priority.
    always_comb
    begin
        unique case (mode_reg) inside
            MODE_SJF:               hit = slot.remaining > req_reg.remaining;
            MODE_PRIO, MODE_PRIO_RR: hit = slot.prio < req_reg.prio;
            default:                hit = 1'b0;
        endcase
    end

    assign place = found_reg || hit;

    // Round-robin slice length is min(time_slice, remaining).
    assign run_len  = (rr_mode && (slice_reg < slot.remaining)) ? slice_reg : slot.remaining;
    assign left_len = slot.remaining - run_len;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        elapsed_next    = elapsed_reg;
        idx_next        = idx_reg;
        wptr_next       = wptr_reg;
        rptr_next       = rptr_reg;
        found_next      = found_reg;
        req_next        = req_reg;
        carry_next      = carry_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_run_next    = res_run_reg;
        res_start_next  = res_start_reg;
        res_fin_next    = res_fin_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = tail_reg;
        ram_wr_data     = carry_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next.id        = s_tdata[7:0];
                    req_next.remaining = s_tdata[23:8];
                    req_next.prio      = s_tdata[31:24];
                    res_status_next    = STAT_ACCEPTED;
                    res_id_next        = '0;
                    res_run_next       = '0;
                    res_start_next     = '0;
                    res_fin_next       = 1'b0;
                    state_next         = ST_DONE;
                    if (s_tuser[0] == OP_ADD)
                    begin
                        if (count_reg == CNT_W'(MAX_TASKS))
                        begin
                            res_status_next = STAT_DROPPED;
                        end
                        else if (sorted_mode && (count_reg != '0))
                        begin
                            // Start the walk at the head; the new task rides in carry.
                            carry_next  = req_next;
                            found_next  = 1'b0;
                            idx_next    = '0;
                            wptr_next   = head_reg;
                            rptr_next   = ptr_inc(head_reg);
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = head_reg;
                            state_next  = ST_SCAN;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = tail_reg;
                            ram_wr_data = req_next;
                            tail_next   = ptr_inc(tail_reg);
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_reg;
                        state_next  = ST_POP;
                    end
                end
            end

            ST_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    // Past the last task: whatever is carried goes into the free slot.
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wptr_reg;
                    ram_wr_data = carry_reg;
                    tail_next   = ptr_inc(tail_reg);
                    count_next  = count_reg + 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    // Once the place is found every later slot moves back by one.
                    if (place)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wptr_reg;
                        ram_wr_data = carry_reg;
                        carry_next  = slot;
                    end
                    found_next  = place;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rptr_reg;
                    wptr_next   = rptr_reg;
                    rptr_next   = ptr_inc(rptr_reg);
                    idx_next    = idx_reg + 1'b1;
                end
            end

            ST_POP:
            begin
                head_next       = ptr_inc(head_reg);
                res_status_next = STAT_SLICE;
                res_id_next     = slot.id;
                res_run_next    = run_len;
                res_start_next  = elapsed_reg;
                elapsed_next    = elapsed_reg + {16'd0, run_len};
                if (rr_mode && (left_len != '0))
                begin
                    // Work remains: requeue at the tail, count unchanged.
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = tail_reg;
                    ram_wr_data     = '{prio: slot.prio, remaining: left_len, id: slot.id};
                    tail_next       = ptr_inc(tail_reg);
                    res_fin_next    = 1'b0;
                end
                else
                begin
                    count_next      = count_reg - 1'b1;
                    res_fin_next    = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            idx_reg       <= '0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_FCFS;
            slice_reg     <= SLICE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            idx_reg       <= idx_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_POLICY_MODE: mode_reg  <= cfg_wdata[2:0];
                    REG_TIME_SLICE:  slice_reg <= cfg_wdata;
                    default:         slice_reg <= slice_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        carry_reg      <= carry_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_run_reg    <= res_run_next;
        res_start_reg  <= res_start_next;
        res_fin_reg    <= res_fin_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_run_reg    <= res_run_reg;
            out_start_reg  <= res_start_reg;
            out_fin_reg    <= res_fin_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_fin_reg, out_start_reg, out_run_reg, out_id_reg};

    // The queue never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("queue count above capacity");

    // An empty ring has head and tail on the same slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    // A sorted insert only runs with room left and never walks past the last task.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((count_reg != CNT_W'(MAX_TASKS)) && (idx_reg <= count_reg)))
        else $error("insert walk out of range");

    // Each accepted request is worked alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request taken while another is in progress");

    // A popped slice that is not finished must have been issued in a round-robin mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP && !res_fin_next) |-> rr_mode)
        else $error("requeue outside round robin");

endmodule

[rtl/tsq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[tb/task_scheduler_queue_tb.sv]
// Self-checking testbench for the task scheduler queue with a built-in scheduling predictor.
module task_scheduler_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_PHASES = 14;

    // One request as it travels on the request stream.
    typedef struct {
        logic   op;
        entry_t job;
    } sched_req_t;

    // One scheduling outcome as it travels on the result stream.
    typedef struct {
        status_t     status;
        logic [7:0]  run_id;
        logic [15:0] run_len;
        logic [31:0] start_at;
        logic        finished;
    } sched_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    // Predictor state: the queue as the block should hold it, plus its registers
    // and the running time counter.
    entry_t      model_queue[$];
    logic [2:0]  policy_mode = MODE_FCFS;
    logic [15:0] quantum = SLICE_RESET;
    logic [31:0] elapsed = '0;

    sched_req_t     request_backlog[$];
    sched_outcome_t awaited_outcomes[$];
    sched_req_t     current_req;
    logic           req_taken = 1'b0;

    int fail_count = 0;
    int n_requests = 0;
    int n_checked = 0;
    int n_slices = 0;
    int n_finished = 0;
    int n_dropped = 0;
    int n_empty = 0;

    // Idle pattern state for both streams.
    int tx_gap = 0;
    int rx_stall = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // Random phases: each one sets a mode and a quantum, then mixes adds and
    // next requests with its own add bias so the queue fills, overflows and drains.
    // Modes 5 and 7 are unused encodings that must act as first come first served.
    logic [2:0]  phase_mode  [NUM_PHASES] = '{MODE_RR, MODE_PRIO, MODE_PRIO_RR, MODE_SJF,
                                              MODE_FCFS, MODE_RR, MODE_PRIO_RR, MODE_RR,
                                              3'd5, MODE_RR, MODE_PRIO_RR, 3'd7, MODE_SJF,
                                              MODE_PRIO};
    logic [15:0] phase_slice [NUM_PHASES] = '{16'd10, 16'd1, 16'd3, 16'hFFFF, 16'd7,
                                              16'd1, 16'hFFFF, 16'd0, 16'd20, 16'hFFFF,
                                              16'd1, 16'd2, 16'd1, 16'd37};
    int          phase_items [NUM_PHASES] = '{100, 120, 150, 120, 100, 120, 100, 40, 80,
                                              100, 120, 80, 120, 100};
    int          phase_adds  [NUM_PHASES] = '{50, 55, 50, 55, 50, 50, 50, 50, 50, 70,
                                              45, 40, 60, 35};

    task_scheduler_queue #(
        .MAX_TASKS(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),   // task_id[7:0], burst_length[23:8], task_priority[31:24]
        .s_tuser(s_tuser),   // opcode[0]
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),   // run_task_id[7:0], run_length[23:8], start_time[55:24],
                             // task_finished[56]
        .m_tuser(m_tuser)    // status[1:0]
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Computes what the block must answer to one request and updates the predicted
    // queue. Ties in the sorted modes go behind the existing entries, so the search
    // looks for the first entry with a strictly worse key.
    function automatic sched_outcome_t schedule_request(sched_req_t req);
        sched_outcome_t res;
        entry_t         head;
        int             place;
        logic [15:0]    run;
        res.status   = STAT_ACCEPTED;
        res.run_id   = '0;
        res.run_len  = '0;
        res.start_at = '0;
        res.finished = 1'b0;
        if (req.op == OP_ADD)
        begin
            if (model_queue.size() >= QUEUE_DEPTH)
            begin
                res.status = STAT_DROPPED;
                n_dropped++;
            end
            else
            begin
                place = model_queue.size();
                // Walking down from the tail leaves the first match in place.
                for (int i = model_queue.size() - 1; i >= 0; i--)
                begin
                    if ((policy_mode == MODE_SJF && model_queue[i].remaining > req.job.remaining)
                        || ((policy_mode == MODE_PRIO || policy_mode == MODE_PRIO_RR)
                            && model_queue[i].prio < req.job.prio))
                        place = i;
                end
                model_queue.insert(place, req.job);
            end
        end
        else if (model_queue.size() == 0)
        begin
            res.status = STAT_EMPTY;
            n_empty++;
        end
        else
        begin
            head = model_queue.pop_front();
            run = head.remaining;
            res.finished = 1'b1;
            // Round-robin modes run at most one quantum and send unfinished work to
            // the tail; a zero quantum requeues the task untouched.
            if (policy_mode == MODE_RR || policy_mode == MODE_PRIO_RR)
            begin
                if (quantum < head.remaining)
                    run = quantum;
                head.remaining = head.remaining - run;
                if (head.remaining != 0)
                begin
                    res.finished = 1'b0;
                    model_queue.push_back(head);
                end
            end
            res.status   = STAT_SLICE;
            res.run_id   = head.id;
            res.run_len  = run;
            res.start_at = elapsed;
            elapsed = elapsed + 32'(run);
            n_slices++;
            if (res.finished)
                n_finished++;
        end
        return res;
    endfunction

    // Mostly short gaps, a few long ones, none at all during calm stretches.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Request driver: presents the next queued request at the falling edge and holds
    // it until the block takes it.
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !req_taken))
        begin
            req_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (request_backlog.size() != 0)
            begin
                current_req = request_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= current_req.job;
                s_tuser  <= current_req.op;
                tx_gap = pick_gap(tx_calm);
                if ($urandom_range(0, 99) == 0)
                    tx_calm = !tx_calm;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_stall = pick_gap(rx_calm);
        end
        if ($urandom_range(0, 199) == 0)
            rx_calm = !rx_calm;
    end

    // Monitor: predicts on each accepted request and checks each accepted result
    // against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        sched_outcome_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_outcomes.push_back(schedule_request(current_req));
                n_requests++;
                req_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d tdata 0x%0h",
                           m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    n_checked++;
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("run_task_id", 32'(want.run_id), 32'(m_tdata[7:0]));
                    check_field("run_length", 32'(want.run_len), 32'(m_tdata[23:8]));
                    check_field("start_time", want.start_at, m_tdata[55:24]);
                    check_field("task_finished", 32'(want.finished), 32'(m_tdata[56]));
                end
            end
        end
    end

    task automatic queue_request(logic op, logic [7:0] id, logic [15:0] burst,
                                 logic [7:0] prio);
        sched_req_t req;
        req.op = op;
        req.job.id = id;
        req.job.remaining = burst;
        req.job.prio = prio;
        request_backlog.push_back(req);
    endtask

    // Random request with a burst mix that favors short jobs but still sweeps the
    // full range, and priorities that mostly collide so ties are common.
    task automatic queue_random_request(int add_pct);
        logic [15:0] burst;
        logic [7:0]  prio;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 50)
            burst = 16'($urandom_range(0, 40));
        else if (r < 80)
            burst = 16'($urandom_range(0, 255));
        else if (r < 92)
            burst = 16'($urandom_range(0, 65535));
        else
            burst = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        prio = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        queue_request(($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_NEXT,
                      8'($urandom_range(0, 255)), burst, prio);
    endtask

    // Waits until the block has answered everything it was given.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || s_tvalid || awaited_outcomes.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Writes both registers back to back and mirrors them in the predictor.
    task automatic write_settings(logic [2:0] mode, logic [15:0] slice_len);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_POLICY_MODE;
        cfg_wdata <= 16'(mode);
        @(negedge clk);
        cfg_addr  <= REG_TIME_SLICE;
        cfg_wdata <= slice_len;
        @(negedge clk);
        cfg_we    <= 1'b0;
        policy_mode = mode;
        quantum = slice_len;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty queue answer, field extremes, and a zero burst that
        // must finish at once with a zero-length slice.
        queue_request(OP_NEXT, 8'h00, 16'h0000, 8'h00);
        queue_request(OP_ADD, 8'h00, 16'h0000, 8'h00);
        queue_request(OP_ADD, 8'hFF, 16'hFFFF, 8'hFF);
        queue_request(OP_NEXT, 8'hFF, 16'hFFFF, 8'hFF);
        queue_request(OP_NEXT, 8'h5A, 16'h1234, 8'hA5);
        wait_idle();

        // Shortest job first with repeated burst values, filled to the brim and then
        // one more add that must be dropped. The full queue carries into the next phase
        // so a mode change over queued tasks is covered too.
        write_settings(MODE_SJF, 16'd1);
        for (int k = 0; k <= QUEUE_DEPTH; k++)
            queue_request(OP_ADD, 8'(16 + k), 16'(((k * 37) % 6) * 1000), 8'(k));
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_settings(phase_mode[p], phase_slice[p]);
            for (int n = 0; n < phase_items[p]; n++)
                queue_random_request(phase_adds[p]);
            wait_idle();
        end

        repeat (20) @(negedge clk);
        $display("Covered %0d requests over %0d settings: %0d slices (%0d finishing),",
                 n_requests, NUM_PHASES + 2, n_slices, n_finished);
        $display("%0d full-queue drops, %0d empty-queue answers, %0d results checked.",
                 n_dropped, n_empty, n_checked);
        if (fail_count == 0)
            $display("task_scheduler_queue regression: pass");
        else
            $display("task_scheduler_queue regression: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #6ms;
        $display("task_scheduler_queue regression: fail");
        $finish;
    end

endmodule
